// ===== rtl/sl1_pkg.sv =====
// Shared types and constants for the smooth L1 loss reduction block.
package sl1_pkg;

   // Element count width and the saturation limit of the count.
   localparam int COUNT_BITS = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Field widths.
   localparam int VALUE_BITS = 16;
   localparam int IN_DATA_BITS = 48;
   localparam int RESULT_BITS = 64;
   localparam int MAG_BITS = 16;
   localparam int RAW_LOSS_BITS = 24;
   localparam int LOSS_BITS = 33;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS = QCNT_BITS + 1;

   // Divider step counter.
   localparam int DIV_STEP_BITS = $clog2(RESULT_BITS);
   localparam logic [DIV_STEP_BITS-1:0] DIV_LAST_STEP = DIV_STEP_BITS'(RESULT_BITS - 1);

   // Configuration register indexes.
   localparam logic CSR_REDUCTION_MODE = 1'b0;
   localparam logic CSR_WEIGHT_ENABLE = 1'b1;

   // Reduction mode codes; the spare code behaves like none.
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_MEAN = 2'd1;
   localparam logic [1:0] MODE_SUM = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // One element loss on its way from the front to the back.
   typedef struct packed {
      logic signed [LOSS_BITS-1:0] loss;
      logic last;
   } entry_type;

   // Write side of the queue.
   typedef struct packed {
      logic valid;
      entry_type entry;
   } q_push_type;

   // Read side of the queue.
   typedef struct packed {
      logic valid;
      entry_type entry;
   } q_head_type;

   // Fill level seen by the front part.
   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
   } q_status_type;

endpackage

// ===== rtl/smooth_l1_loss_reduce.sv =====
// Top level of the smooth L1 loss block with weighting and reduction.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata: prediction, target, weight; tlast: last_in
//   rsp      out        rsp_tvalid/rsp_tready  tdata: loss_value; tlast: last_out
//   csr      in         csr_we                 csr_index, csr_wdata
//
// Items are taken one per cycle while the queue has room; an element loss passes through
// a three-stage front pipeline and an eight-entry queue, and the back part consumes one
// queue entry per cycle while it is running and its output register is free. A mean result
// adds the steps of the one-bit-per-cycle divider plus an emit state, once per run.
// Reset is synchronous and clears configuration, accumulator, count and all valids.
// A stalled result holds in the output register while items keep entering until the
// queue is full.
module smooth_l1_loss_reduce import sl1_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // Fields from bit 0: prediction[15:0], target[31:16], weight[47:32].
   input  logic [IN_DATA_BITS-1:0] req_tdata,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // Fields from bit 0: loss_value[63:0].
   output logic [RESULT_BITS-1:0]  rsp_tdata,
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [1:0]              csr_wdata
);

   logic [1:0]   mode_ff, mode_in;
   logic         weight_en_ff, weight_en_in;
   q_push_type   q_push;
   q_head_type   q_head;
   q_status_type q_status;
   logic         q_pop;

   // Configuration register writes.
   always_comb begin
      mode_in = mode_ff;
      weight_en_in = weight_en_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_REDUCTION_MODE: mode_in = csr_wdata;
            CSR_WEIGHT_ENABLE:  weight_en_in = csr_wdata[0];
            default:            mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         weight_en_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         weight_en_ff <= weight_en_in;
      end
   end

   sl1_front u_front (
      .clock         (clock),
      .reset         (reset),
      .weight_enable (weight_en_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .q_status      (q_status),
      .q_push        (q_push)
   );

   sl1_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   sl1_back u_back (
      .clock          (clock),
      .reset          (reset),
      .reduction_mode (mode_ff),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );

endmodule

// ===== rtl/sl1_front.sv =====
// Front part: accepts items and computes each element loss in three stages.
module sl1_front import sl1_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    weight_enable,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // Fields from bit 0: prediction[15:0], target[31:16], weight[47:32].
   input  logic [IN_DATA_BITS-1:0] req_tdata,
   input  logic                    req_tlast,
   input  q_status_type            q_status,
   output q_push_type              q_push
);

   logic                          v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [MAG_BITS-1:0]           d_ff, d_in;
   logic signed [VALUE_BITS-1:0]  w1_ff, w1_in, w2_ff, w2_in;
   logic                          last1_ff, last1_in, last2_ff, last2_in, last3_ff, last3_in;
   logic [RAW_LOSS_BITS-1:0]      raw_ff, raw_in;
   logic signed [LOSS_BITS-1:0]   loss_ff, loss_in;

   logic signed [VALUE_BITS:0]    diff;
   logic [OCC_BITS-1:0]           occupancy;
   logic [2*8-1:0]                d_sq;
   logic signed [RAW_LOSS_BITS+VALUE_BITS:0] prod;
   logic                          accept;

   // Room is kept in the queue for every item still in the stages.
   assign occupancy = OCC_BITS'(q_status.count) + OCC_BITS'(v1_ff) + OCC_BITS'(v2_ff)
                      + OCC_BITS'(v3_ff);
   assign req_tready = occupancy < OCC_BITS'(QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   // Stage one: magnitude of the difference.
   always_comb begin
      diff = $signed({req_tdata[VALUE_BITS-1], req_tdata[VALUE_BITS-1:0]})
             - $signed({req_tdata[2*VALUE_BITS-1], req_tdata[2*VALUE_BITS-1:VALUE_BITS]});
      d_in = diff[VALUE_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
      w1_in = $signed(req_tdata[3*VALUE_BITS-1:2*VALUE_BITS]);
      last1_in = req_tlast;
      v1_in = accept;
   end

   // Stage two: quadratic loss below 1.0, linear loss above.
   always_comb begin
      d_sq = d_ff[7:0] * d_ff[7:0];
      if (d_ff < MAG_BITS'(256)) begin
         raw_in = RAW_LOSS_BITS'(d_sq[15:1]);
      end else begin
         raw_in = {d_ff, 8'h00} - RAW_LOSS_BITS'(32768);
      end
      w2_in = w1_ff;
      last2_in = last1_ff;
      v2_in = v1_ff;
   end

   // Stage three: optional weighting; the arithmetic shift rounds toward minus infinity.
   always_comb begin
      prod = $signed({1'b0, raw_ff}) * w2_ff;
      if (weight_enable) begin
         loss_in = prod[RAW_LOSS_BITS+VALUE_BITS:8];
      end else begin
         loss_in = $signed(LOSS_BITS'(raw_ff));
      end
      last3_in = last2_ff;
      v3_in = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      d_ff <= d_in;
      w1_ff <= w1_in;
      last1_ff <= last1_in;
      raw_ff <= raw_in;
      w2_ff <= w2_in;
      last2_ff <= last2_in;
      loss_ff <= loss_in;
      last3_ff <= last3_in;
   end

   assign q_push.valid = v3_ff;
   assign q_push.entry.loss = loss_ff;
   assign q_push.entry.last = last3_ff;

endmodule

// ===== rtl/sl1_queue.sv =====
// Short queue of element losses between the front and the back part.
module sl1_queue import sl1_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_push_type   q_push,
   input  logic         q_pop,
   output q_head_type   q_head,
   output q_status_type q_status
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_pop;

   // The front only pushes when there is room.
   assign do_pop = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + QCNT_BITS'(q_push.valid) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (q_push.valid) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   assign q_head.valid = count_ff != '0;
   assign q_head.entry = slot_ff[rd_ptr_ff];
   assign q_status.count = count_ff;

endmodule

// ===== rtl/sl1_back.sv =====
// Back part: reduction, mean divider and the result register.
module sl1_back import sl1_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             reduction_mode,
   input  q_head_type             q_head,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: loss_value[63:0].
   output logic [RESULT_BITS-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [RESULT_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic                          out_valid_ff, out_valid_in;
   logic [RESULT_BITS-1:0]        out_data_ff, out_data_in;
   logic                          out_last_ff, out_last_in;
   logic [RESULT_BITS-1:0]        quo_ff, quo_in;
   logic [COUNT_BITS-1:0]         rem_ff, rem_in;
   logic [COUNT_BITS-1:0]         divisor_ff, divisor_in;
   logic                          neg_ff, neg_in;
   logic [DIV_STEP_BITS-1:0]      step_ff, step_in;

   logic                          out_free;
   logic                          reducing;
   logic signed [RESULT_BITS:0]   sum_wide;
   logic signed [RESULT_BITS-1:0] sat_sum;
   logic [COUNT_BITS-1:0]         count_next;
   logic [COUNT_BITS:0]           rem_shift;
   logic                          rem_fits;

   assign out_free = !out_valid_ff || rsp_tready;
   assign q_pop = (state_ff == ST_RUN) && out_free && q_head.valid;
   assign reducing = (reduction_mode == MODE_MEAN) || (reduction_mode == MODE_SUM);

   // Saturating accumulate and saturating count.
   always_comb begin
      sum_wide = $signed({acc_ff[RESULT_BITS-1], acc_ff})
                 + $signed((RESULT_BITS+1)'(q_head.entry.loss));
      if (sum_wide[RESULT_BITS] != sum_wide[RESULT_BITS-1]) begin
         sat_sum = sum_wide[RESULT_BITS] ? {1'b1, {(RESULT_BITS-1){1'b0}}}
                                         : {1'b0, {(RESULT_BITS-1){1'b1}}};
      end else begin
         sat_sum = sum_wide[RESULT_BITS-1:0];
      end
      count_next = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   // One restoring divide step on the magnitude.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[RESULT_BITS-1]};
      rem_fits = rem_shift >= {1'b0, divisor_ff};
   end

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      count_in = count_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (q_pop) begin
               if (!reducing) begin
                  out_valid_in = 1'b1;
                  out_data_in = RESULT_BITS'(q_head.entry.loss);
                  out_last_in = q_head.entry.last;
                  if (q_head.entry.last) begin
                     acc_in = '0;
                     count_in = '0;
                  end
               end else if (!q_head.entry.last) begin
                  acc_in = sat_sum;
                  count_in = count_next;
               end else begin
                  acc_in = '0;
                  count_in = '0;
                  if (reduction_mode == MODE_SUM) begin
                     out_valid_in = 1'b1;
                     out_data_in = sat_sum;
                     out_last_in = 1'b1;
                  end else begin
                     neg_in = sat_sum[RESULT_BITS-1];
                     quo_in = sat_sum[RESULT_BITS-1] ? RESULT_BITS'(-sat_sum)
                                                     : RESULT_BITS'(sat_sum);
                     rem_in = '0;
                     divisor_in = count_next;
                     step_in = '0;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_fits ? COUNT_BITS'(rem_shift - {1'b0, divisor_ff})
                              : rem_shift[COUNT_BITS-1:0];
            quo_in = {quo_ff[RESULT_BITS-2:0], rem_fits};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST_STEP) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in = neg_ff ? -quo_ff : quo_ff;
               out_last_in = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         acc_ff <= '0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff <= neg_in;
      step_ff <= step_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the smooth L1 loss block with weighting and reduction.
module tb_top;
   import sl1_pkg::*;

   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

   // One expected result beat.
   typedef struct {
      longint loss_value;
      logic   last_out;
   } loss_beat_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // Fields from bit 0: prediction[15:0], target[31:16], weight[47:32].
   logic [IN_DATA_BITS-1:0] req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // Fields from bit 0: loss_value[63:0].
   logic [RESULT_BITS-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic                    csr_index = 1'b0;
   logic [1:0]              csr_wdata = '0;

   // Mirror of the block's configuration and run state.
   logic [1:0]              cur_mode = MODE_NONE;
   logic                    cur_weighted = 1'b0;
   longint                  run_total = 0;
   logic [COUNT_BITS-1:0]   run_count = '0;

   loss_beat_type           pending_losses[$];
   int                      fail_count = 0;
   int                      idle_cycles = 0;
   int unsigned             req_idle_pct = 0;
   int unsigned             rsp_stall_pct = 0;

   smooth_l1_loss_reduce i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Loss of one element in Q16.16, weighted when enabled.
   function automatic longint predict_loss(logic signed [VALUE_BITS-1:0] pred,
                                           logic signed [VALUE_BITS-1:0] tgt,
                                           logic signed [VALUE_BITS-1:0] wgt);
      longint diff;
      longint mag;
      longint loss;
      diff = longint'(pred) - longint'(tgt);
      mag = (diff < 0) ? -diff : diff;
      if (mag < 256) begin
         loss = (mag * mag) >>> 1;
      end else begin
         loss = mag * 256 - 32768;
      end
      // The arithmetic shift rounds the Q24.24 product toward minus infinity.
      if (cur_weighted) begin
         loss = (loss * longint'(wgt)) >>> 8;
      end
      return loss;
   endfunction

   function automatic longint saturating_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

   // Folds one accepted element into the run state and queues any result it causes.
   function automatic void reduce_element(logic signed [VALUE_BITS-1:0] pred,
                                          logic signed [VALUE_BITS-1:0] tgt,
                                          logic signed [VALUE_BITS-1:0] wgt,
                                          logic last);
      longint loss;
      loss_beat_type beat;
      loss = predict_loss(pred, tgt, wgt);
      if (cur_mode != MODE_MEAN && cur_mode != MODE_SUM) begin
         beat.loss_value = loss;
         beat.last_out = last;
         pending_losses.push_back(beat);
      end else begin
         run_total = saturating_add(run_total, loss);
         if (run_count < COUNT_MAX) begin
            run_count++;
         end
         if (last) begin
            beat.loss_value = (cur_mode == MODE_SUM) ? run_total
                                                     : run_total / longint'(run_count);
            beat.last_out = 1'b1;
            pending_losses.push_back(beat);
         end
      end
      if (last) begin
         run_total = 0;
         run_count = '0;
      end
   endfunction

   // Sends one element beat, idling beforehand at random, and predicts its result.
   task automatic push_element(input logic signed [VALUE_BITS-1:0] pred,
                               input logic signed [VALUE_BITS-1:0] tgt,
                               input logic signed [VALUE_BITS-1:0] wgt,
                               input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {wgt, tgt, pred};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reduce_element(pred, tgt, wgt, last);
   endtask

   // Lets every expected result arrive, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_losses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_REDUCTION_MODE) begin
         cur_mode = data;
      end else begin
         cur_weighted = data[0];
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [VALUE_BITS-1:0] extreme_value();
      case ($urandom_range(3))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   // Element losses on both sides of the 1.0 knee and at the widest differences.
   task automatic test_element_loss();
      write_csr(CSR_REDUCTION_MODE, MODE_NONE);
      write_csr(CSR_WEIGHT_ENABLE, 2'd0);
      push_element(16'sd0, 16'sd0, 16'sd0, 1'b0);
      push_element(16'sd255, 16'sd0, 16'sd0, 1'b1);
      push_element(16'sd256, 16'sd0, 16'sd0, 1'b0);
      push_element(16'sd0, 16'sd257, 16'sd0, 1'b0);
      push_element(16'sh7FFF, 16'sh8000, 16'sd0, 1'b0);
      push_element(16'sh8000, 16'sh7FFF, 16'sd0, 1'b1);
      drain();
   endtask

   // Weight extremes and the round toward minus infinity of negative products.
   task automatic test_weighting();
      write_csr(CSR_WEIGHT_ENABLE, 2'd1);
      push_element(16'sd768, 16'sd0, 16'sh8000, 1'b0);
      push_element(16'sd768, 16'sd0, 16'sh7FFF, 1'b0);
      push_element(16'sd768, 16'sd0, 16'sd0, 1'b0);
      push_element(16'sd3, 16'sd0, -16'sd1, 1'b0);
      push_element(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
      drain();
   endtask

   // The spare mode code acts like none; bit 1 of the weight enable is ignored.
   task automatic test_spare_mode();
      write_csr(CSR_REDUCTION_MODE, MODE_SPARE);
      write_csr(CSR_WEIGHT_ENABLE, 2'd2);
      push_element(16'sd100, -16'sd100, 16'sd512, 1'b0);
      push_element(-16'sd1000, 16'sd0, 16'sd512, 1'b1);
      drain();
   endtask

   task automatic test_sum_runs();
      write_csr(CSR_REDUCTION_MODE, MODE_SUM);
      write_csr(CSR_WEIGHT_ENABLE, 2'd1);
      push_element(16'sd256, 16'sd0, 16'sd700, 1'b0);
      push_element(16'sd10, 16'sd0, -16'sd3, 1'b0);
      push_element(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
      push_element(16'sd40, 16'sd0, 16'sd256, 1'b1);
      drain();
   endtask

   // A negative total that does not divide evenly, so the quotient truncates.
   task automatic test_mean_runs();
      write_csr(CSR_REDUCTION_MODE, MODE_MEAN);
      push_element(16'sd256, 16'sd0, -16'sd300, 1'b0);
      push_element(16'sd0, 16'sd256, -16'sd300, 1'b0);
      push_element(16'sd3, 16'sd0, -16'sd1, 1'b1);
      push_element(-16'sd5, 16'sd90, 16'sh8000, 1'b1);
      drain();
   endtask

   // A total built under sum survives a detour through mode none and ends as a mean.
   task automatic test_mode_switch();
      write_csr(CSR_REDUCTION_MODE, MODE_SUM);
      write_csr(CSR_WEIGHT_ENABLE, 2'd0);
      push_element(16'sd600, 16'sd0, 16'sd0, 1'b0);
      push_element(16'sd0, 16'sd77, 16'sd0, 1'b0);
      drain();
      write_csr(CSR_REDUCTION_MODE, MODE_NONE);
      push_element(16'sd1000, -16'sd1000, 16'sd0, 1'b0);
      drain();
      write_csr(CSR_REDUCTION_MODE, MODE_MEAN);
      push_element(-16'sd2000, 16'sd0, 16'sd0, 1'b1);
      drain();
   endtask

   // Runs of random elements under random settings, switching settings between segments.
   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned n_items);
      int unsigned sent;
      int unsigned run_len;
      logic signed [VALUE_BITS-1:0] pred;
      logic signed [VALUE_BITS-1:0] tgt;
      logic signed [VALUE_BITS-1:0] wgt;
      sent = 0;
      run_len = 0;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent < n_items) begin
         write_csr(CSR_REDUCTION_MODE, 2'($urandom_range(3)));
         write_csr(CSR_WEIGHT_ENABLE, 2'($urandom_range(3)));
         repeat (40) begin
            if (run_len == 0) begin
               run_len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            end
            run_len--;
            // Mix of differences near the knee, anywhere, and at the field limits.
            tgt = 16'($urandom);
            case ($urandom_range(3))
               0: pred = 16'(int'(tgt) + int'($urandom_range(600)) - 300);
               1: pred = 16'($urandom);
               2: begin
                  pred = extreme_value();
                  tgt = extreme_value();
               end
               default: pred = 16'(int'(tgt) + int'($urandom_range(511)) - 255);
            endcase
            case ($urandom_range(2))
               0: wgt = 16'($urandom);
               1: wgt = 16'(int'($urandom_range(1024)) - 512);
               default: wgt = extreme_value();
            endcase
            push_element(pred, tgt, wgt, run_len == 0);
            sent++;
         end
         drain();
      end
   endtask

   // Receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compares each result beat with the oldest expected loss.
   always @(posedge clock) begin
      loss_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_losses.size() == 0) begin
            $error("unexpected result beat: loss_value %0d last_out %0b",
                   $signed(rsp_tdata), rsp_tlast);
            fail_count++;
         end else begin
            want = pending_losses.pop_front();
            if (rsp_tdata !== want.loss_value) begin
               $error("loss_value: expected %0d, actual %0d", want.loss_value,
                      $signed(rsp_tdata));
               fail_count++;
            end
            if (rsp_tlast !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_element_loss();
      test_weighting();
      test_spare_mode();
      test_sum_runs();
      test_mean_runs();
      test_mode_switch();
      test_random_traffic(0, 0, 160);
      test_random_traffic(84, 0, 160);
      test_random_traffic(0, 84, 160);
      test_random_traffic(37, 37, 160);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== smooth_l1_loss_reduce.f =====
rtl/sl1_pkg.sv
rtl/sl1_front.sv
rtl/sl1_queue.sv
rtl/sl1_back.sv
rtl/smooth_l1_loss_reduce.sv
tb/tb_top.sv
